[rtl/per_cell_majority_vote_core_defines.svh]
`ifndef PER_CELL_MAJORITY_VOTE_CORE_DEFINES_SVH
`define PER_CELL_MAJORITY_VOTE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PCMV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PCMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcmv_pkg.sv]
package pcmv_pkg;

  localparam int REQ_W      = 2;
  localparam int VAL_W      = 4;
  localparam int IDX_W      = 7;
  localparam int MODE_W     = 2;
  localparam int FRAME_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_CELL_COUNT  = 81;
  localparam int DEF_VALUE_COUNT = 10;
  localparam int DEF_COUNT_BITS  = 8;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [MODE_W-1:0] SRC_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] SRC_LATEST = 2'd1;
  localparam logic [MODE_W-1:0] SRC_VOTE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FRAMES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTE_FRAMES = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_ZERO     = 8'd0;
  localparam logic [FRAME_W-1:0] FRAME_ONE      = 8'd1;
  localparam logic [FRAME_W-1:0] FRAME_MAX      = 8'hFF;
  localparam logic [FRAME_W-1:0] SKIP_RESET     = 8'd0;
  localparam logic [FRAME_W-1:0] MIN_VOTE_RESET = 8'd3;

endpackage

[rtl/pcmv_ram.sv]
module pcmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/per_cell_majority_vote_core.sv]
// Query path: an accepted query word is registered in stage s1, then written into the result
// queue, from which it is offered as a result word for the receiver to take.
// Throughput: one word per cycle, with the count RAM's read-modify-write per push bypassed for
// back-to-back words; the input stalls while three query results are queued or in flight.
// Reset: asynchronous, active low; counters, frame numbers, position and row valid bits
// clear at once, registers return to skip_frames 0 and min_vote_frames 3.
`include "per_cell_majority_vote_core_defines.svh"

module per_cell_majority_vote_core #(
  parameter int CELL_COUNT  = pcmv_pkg::DEF_CELL_COUNT,
  parameter int VALUE_COUNT = pcmv_pkg::DEF_VALUE_COUNT,
  parameter int COUNT_BITS  = pcmv_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcmv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcmv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pcmv_pkg::REQ_W-1:0]      req_type_i,
  input  logic [pcmv_pkg::VAL_W-1:0]      cell_value_i,
  input  logic [pcmv_pkg::IDX_W-1:0]      cell_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pcmv_pkg::VAL_W-1:0]      voted_value_o,
  output logic [pcmv_pkg::MODE_W-1:0]     source_mode_o
);
  import pcmv_pkg::*;

  localparam int ADDR_W    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W     = VALUE_COUNT * COUNT_BITS;
  localparam int ROW_W     = CNT_W + VAL_W;
  localparam int LVL       = $clog2(VALUE_COUNT);
  localparam int LEAVES    = 1 << LVL;
  localparam int IDX_EXT_W = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
  localparam int OUT_SLOTS = 3;
  localparam int PTR_W     = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [ADDR_W-1:0]     LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0]     ADDR_ONE   = ADDR_W'(1);
  localparam logic [VAL_W:0]        VAL_LIMIT  = (VAL_W + 1)'(VALUE_COUNT);
  localparam logic [IDX_EXT_W-1:0]  CELL_LIMIT = IDX_EXT_W'(CELL_COUNT);
  localparam logic [PTR_W:0]        OUT_LIMIT  = (PTR_W + 1)'(OUT_SLOTS);
  localparam logic [PTR_W-1:0]      PTR_LAST   = PTR_W'(OUT_SLOTS - 1);
  localparam logic [PTR_W-1:0]      PTR_ONE    = PTR_W'(1);

  typedef struct packed {
    logic              vld;
    logic              is_query;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [MODE_W-1:0] mode;
  } stage_t;

  logic [FRAME_W-1:0]    skip_q, skip_d;
  logic [FRAME_W-1:0]    min_vote_q, min_vote_d;
  logic [ADDR_W-1:0]     pos_q, pos_d;
  logic [FRAME_W-1:0]    seen_q, seen_d;
  logic [FRAME_W-1:0]    counted_q, counted_d;
  logic [CELL_COUNT-1:0] row_vld_q, row_vld_d;
  stage_t                s1_q, s1_d;
  logic                  fwd_vld_q, fwd_vld_d;
  logic [ADDR_W-1:0]     fwd_addr_q, fwd_addr_d;
  logic [ROW_W-1:0]      fwd_row_q, fwd_row_d;
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]      out_cnt_q, out_cnt_d;
  logic [VAL_W-1:0]      out_val_q [OUT_SLOTS];
  logic [MODE_W-1:0]     out_mode_q [OUT_SLOTS];

  logic                  in_fire, is_push, is_query, is_clear;
  logic                  counted_now, val_ok, at_last, idx_ok;
  logic [IDX_EXT_W-1:0]  idx_ext;
  logic [ADDR_W-1:0]     raddr;
  logic [MODE_W-1:0]     query_mode;
  logic [PTR_W:0]        pend;

  logic [ROW_W-1:0]      ram_rdata, row_raw, new_row;
  logic                  fwd_hit, row_ok, we;
  logic [CNT_W-1:0]      counts, new_counts;
  logic [LEAVES*COUNT_BITS-1:0] cnt_pad;
  logic [COUNT_BITS-1:0] slot;
  logic [VAL_W-1:0]      latest, best, result_val;
  logic [COUNT_BITS-1:0] tree_cnt [2*LEAVES-1];
  logic [VAL_W-1:0]      tree_val [2*LEAVES-1];
  logic                  out_push, out_pop;

  // Front end: request decode, frame bookkeeping, configuration writes and RAM read address.
  assign pend       = {1'b0, out_cnt_q} + {{PTR_W{1'b0}}, s1_q.vld & s1_q.is_query};
  assign in_ready_o = (pend < OUT_LIMIT);
  assign in_fire    = in_valid_i & in_ready_o;
  assign is_push    = (req_type_i == REQ_PUSH);
  assign is_query   = (req_type_i == REQ_QUERY);
  assign is_clear   = (req_type_i == REQ_CLEAR);
  assign counted_now = (seen_q >= skip_q);
  assign val_ok     = ({1'b0, cell_value_i} < VAL_LIMIT);
  assign at_last    = (pos_q == LAST_CELL);
  assign idx_ext    = IDX_EXT_W'(cell_index_i);
  assign idx_ok     = (idx_ext < CELL_LIMIT);
  assign raddr      = is_query ? (idx_ok ? idx_ext[ADDR_W-1:0] : '0) : pos_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (!idx_ok || (counted_q == FRAME_ZERO)) begin
      query_mode = SRC_NONE;
    end else if (counted_q < min_vote_q) begin
      query_mode = SRC_LATEST;
    end else begin
      query_mode = SRC_VOTE;
    end
  end

  always_comb begin
    s1_d          = '0;
    s1_d.vld      = in_fire & (is_push | is_query);
    s1_d.is_query = is_query;
    s1_d.wr       = is_push & counted_now & val_ok;
    s1_d.addr     = raddr;
    s1_d.value    = cell_value_i;
    s1_d.mode     = query_mode;

    pos_d     = pos_q;
    seen_d    = seen_q;
    counted_d = counted_q;
    if (in_fire && is_push) begin
      if (at_last) begin
        pos_d = '0;
        if (seen_q != FRAME_MAX) begin
          seen_d = seen_q + FRAME_ONE;
        end
        if (counted_now && (counted_q != FRAME_MAX)) begin
          counted_d = counted_q + FRAME_ONE;
        end
      end else begin
        pos_d = pos_q + ADDR_ONE;
      end
    end else if (in_fire && is_clear) begin
      pos_d     = '0;
      seen_d    = FRAME_ZERO;
      counted_d = FRAME_ZERO;
    end

    skip_d     = skip_q;
    min_vote_d = min_vote_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SKIP_FRAMES:     skip_d = cfg_data_i;
        CFG_MIN_VOTE_FRAMES: min_vote_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  pcmv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CELL_COUNT),
    .ADDR_W(ADDR_W)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_q.addr),
    .wdata_i(new_row),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Back end: count update for pushes and vote selection for queries.
  assign fwd_hit = fwd_vld_q && (fwd_addr_q == s1_q.addr);
  assign row_raw = fwd_hit ? fwd_row_q : ram_rdata;
  assign row_ok  = fwd_hit || row_vld_q[s1_q.addr];
  assign counts  = row_ok ? row_raw[CNT_W-1:0] : '0;
  assign latest  = row_raw[ROW_W-1 -: VAL_W];
  assign we      = s1_q.vld & s1_q.wr;
  assign new_row = {s1_q.value, new_counts};
  assign cnt_pad = (LEAVES * COUNT_BITS)'(counts);

  always_comb begin
    slot       = '0;
    new_counts = counts;
    for (int v = 0; v < VALUE_COUNT; v++) begin
      slot = counts[v*COUNT_BITS +: COUNT_BITS];
      if ((VAL_W'(v) == s1_q.value) && (slot != COUNT_MAX)) begin
        new_counts[v*COUNT_BITS +: COUNT_BITS] = slot + COUNT_ONE;
      end
    end
  end

  // The left subtree always holds the lower values, so it keeps a tie.
  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      tree_cnt[LEAVES-1+k] = cnt_pad[k*COUNT_BITS +: COUNT_BITS];
      tree_val[LEAVES-1+k] = VAL_W'(k);
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (tree_cnt[2*n+2] > tree_cnt[2*n+1]) begin
        tree_cnt[n] = tree_cnt[2*n+2];
        tree_val[n] = tree_val[2*n+2];
      end else begin
        tree_cnt[n] = tree_cnt[2*n+1];
        tree_val[n] = tree_val[2*n+1];
      end
    end
  end

  assign best = tree_val[0];

  always_comb begin
    case (s1_q.mode)
      SRC_LATEST: result_val = latest;
      SRC_VOTE:   result_val = best;
      default:    result_val = '0;
    endcase
  end

  always_comb begin
    row_vld_d = row_vld_q;
    if (we) begin
      row_vld_d[s1_q.addr] = 1'b1;
    end
    if (in_fire && is_clear) begin
      row_vld_d = '0;
    end
    fwd_vld_d  = we;
    fwd_addr_d = s1_q.addr;
    fwd_row_d  = new_row;
  end

  // Result queue.
  assign out_push    = s1_q.vld & s1_q.is_query;
  assign out_valid_o = (out_cnt_q != '0);
  assign out_pop     = out_valid_o & out_ready_i;
  assign voted_value_o = out_val_q[rd_ptr_q];
  assign source_mode_o = out_mode_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    out_cnt_d = out_cnt_q;
    if (out_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
    end
    if (out_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
    end
    if (out_push && !out_pop) begin
      out_cnt_d = out_cnt_q + PTR_ONE;
    end else if (!out_push && out_pop) begin
      out_cnt_d = out_cnt_q - PTR_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= SKIP_RESET;
      min_vote_q <= MIN_VOTE_RESET;
      pos_q      <= '0;
      seen_q     <= FRAME_ZERO;
      counted_q  <= FRAME_ZERO;
      row_vld_q  <= '0;
      s1_q       <= '0;
      fwd_vld_q  <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      out_cnt_q  <= '0;
    end else begin
      skip_q     <= skip_d;
      min_vote_q <= min_vote_d;
      pos_q      <= pos_d;
      seen_q     <= seen_d;
      counted_q  <= counted_d;
      row_vld_q  <= row_vld_d;
      s1_q       <= s1_d;
      fwd_vld_q  <= fwd_vld_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= fwd_addr_d;
    fwd_row_q  <= fwd_row_d;
    if (out_push) begin
      out_val_q[wr_ptr_q]  <= result_val;
      out_mode_q[wr_ptr_q] <= s1_q.mode;
    end
  end

  `PCMV_ASSERT_NEXT(a_clear_empties_rows, in_fire && is_clear, row_vld_q == '0,
                    "Row valid bits not empty after a clear word.")
  `PCMV_ASSERT_IMPL(a_position_in_range, 1'b1, pos_q <= LAST_CELL,
                    "Cell position beyond the last cell.")
  `PCMV_ASSERT_IMPL(a_result_room, 1'b1, pend <= OUT_LIMIT,
                    "More query results pending than the result queue holds.")

endmodule

[test/per_cell_majority_vote_core_checker.sv]
`timescale 1ns / 100ps

module per_cell_majority_vote_core_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pcmv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcmv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [pcmv_pkg::REQ_W-1:0]      req_type_i,
  input  logic [pcmv_pkg::VAL_W-1:0]      cell_value_i,
  input  logic [pcmv_pkg::IDX_W-1:0]      cell_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [pcmv_pkg::VAL_W-1:0]      voted_value_i,
  input  logic [pcmv_pkg::MODE_W-1:0]     source_mode_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              result_count_o,
  output int                              vote_count_o
);
  import pcmv_pkg::*;

  localparam int CELLS  = DEF_CELL_COUNT;
  localparam int DIGITS = DEF_VALUE_COUNT;
  localparam logic [DEF_COUNT_BITS-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [MODE_W-1:0] mode;
  } vote_t;

  logic [DEF_COUNT_BITS-1:0] tally [CELLS][DIGITS];
  logic [VAL_W-1:0]          last_digit [CELLS];
  logic [IDX_W-1:0]          position;
  logic [FRAME_W-1:0]        frames_seen;
  logic [FRAME_W-1:0]        frames_used;
  logic [FRAME_W-1:0]        skip_cfg;
  logic [FRAME_W-1:0]        min_cfg;
  vote_t                     expected_votes [$];

  function automatic void clear_tallies();
    foreach (tally[c, d]) tally[c][d] = '0;
    position    = '0;
    frames_seen = FRAME_ZERO;
    frames_used = FRAME_ZERO;
  endfunction

  function automatic void take_push(input logic [VAL_W-1:0] digit);
    logic [IDX_W-1:0] at_cell;
    logic             counted;
    at_cell = (position >= CELLS) ? '0 : position;
    counted = (frames_seen >= skip_cfg);
    if (counted && digit < DIGITS) begin
      if (tally[at_cell][digit] != COUNT_FULL) begin
        tally[at_cell][digit] = tally[at_cell][digit] + 1'b1;
      end
      last_digit[at_cell] = digit;
    end
    if (at_cell == CELLS - 1) begin
      position = '0;
      if (frames_seen != FRAME_MAX) frames_seen = frames_seen + FRAME_ONE;
      if (counted && frames_used != FRAME_MAX) frames_used = frames_used + FRAME_ONE;
    end else begin
      position = at_cell + 1'b1;
    end
  endfunction

  function automatic vote_t predict_vote(input logic [IDX_W-1:0] idx);
    vote_t            res;
    logic [VAL_W-1:0] best;
    res.value = '0;
    res.mode  = SRC_NONE;
    if (idx >= CELLS || frames_used == FRAME_ZERO) return res;
    if (frames_used < min_cfg) begin
      res.value = last_digit[idx];
      res.mode  = SRC_LATEST;
      return res;
    end
    best = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (tally[idx][d] > tally[idx][best]) best = d[VAL_W-1:0];
    end
    res.value = best;
    res.mode  = SRC_VOTE;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vote_t want;
    if (!rst_ni) begin
      clear_tallies();
      foreach (last_digit[c]) last_digit[c] = '0;
      skip_cfg = SKIP_RESET;
      min_cfg  = MIN_VOTE_RESET;
      expected_votes.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      result_count_o = 0;
      vote_count_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_votes.size() == 0) begin
          $error("Result word with no query waiting: voted_value %0d, source_mode %0d",
                 voted_value_i, source_mode_i);
          fail_count_o++;
        end else begin
          want = expected_votes.pop_front();
          result_count_o++;
          if (want.mode == SRC_VOTE) vote_count_o++;
          if (voted_value_i !== want.value) begin
            $error("voted_value: expected %0d, actual %0d", want.value, voted_value_i);
            fail_count_o++;
          end
          if (source_mode_i !== want.mode) begin
            $error("source_mode: expected %0d, actual %0d", want.mode, source_mode_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SKIP_FRAMES) begin
          skip_cfg = cfg_data_i;
        end else if (cfg_index_i == CFG_MIN_VOTE_FRAMES) begin
          min_cfg = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (req_type_i)
          REQ_PUSH: begin
            take_push(cell_value_i);
          end
          REQ_QUERY: begin
            expected_votes.insert(expected_votes.size(), predict_vote(cell_index_i));
          end
          REQ_CLEAR: begin
            clear_tallies();
          end
          default: begin
          end
        endcase
      end
      pending_o = expected_votes.size();
    end
  end

endmodule

[test/per_cell_majority_vote_core_test.sv]
`timescale 1ns / 100ps

module per_cell_majority_vote_core_test;
  import pcmv_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      req_type_i = '0;
  logic [VAL_W-1:0]      cell_value_i = '0;
  logic [IDX_W-1:0]      cell_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [VAL_W-1:0]      voted_value_o;
  logic [MODE_W-1:0]     source_mode_o;

  int fail_count;
  int pending;
  int result_count;
  int vote_count;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  per_cell_majority_vote_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .cell_value_i  (cell_value_i),
    .cell_index_i  (cell_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .voted_value_o (voted_value_o),
    .source_mode_o (source_mode_o)
  );

  per_cell_majority_vote_core_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .cell_value_i   (cell_value_i),
    .cell_index_i   (cell_index_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .voted_value_i  (voted_value_o),
    .source_mode_i  (source_mode_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .vote_count_o   (vote_count)
  );

  // The receiver may be told once to hold off for a long stretch so that
  // queued results back up into the input.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] digit,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    cell_value_i <= digit;
    cell_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_digit(input logic [VAL_W-1:0] digit);
    send_word(REQ_PUSH, digit, IDX_W'($urandom_range(127)));
  endtask

  task automatic ask_cell(input logic [IDX_W-1:0] idx);
    send_word(REQ_QUERY, VAL_W'($urandom_range(15)), idx);
  endtask

  // Pushes and clears produce no result, so a drain of DRAIN_CYCLES follows the
  // last result before the block is treated as idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Pushes so that frames complete and queries in a share set by query_pct, with rare clears,
  // unused request types and out-of-range values and cells mixed in.
  task automatic random_phase(input logic [FRAME_W-1:0] skip, input logic [FRAME_W-1:0] need,
                              input int idle_pct, input int stall_pct, input int words,
                              input int query_pct);
    int roll;
    write_reg(CFG_SKIP_FRAMES, skip);
    write_reg(CFG_MIN_VOTE_FRAMES, need);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_word(REQ_CLEAR, VAL_W'($urandom_range(15)), IDX_W'($urandom_range(127)));
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(999);
      if (roll < 5) begin
        send_word(REQ_CLEAR, VAL_W'($urandom_range(15)), IDX_W'($urandom_range(127)));
      end else if (roll < 15) begin
        send_word(REQ_UNUSED, VAL_W'($urandom_range(15)), IDX_W'($urandom_range(127)));
      end else if (roll < 15 + query_pct * 10) begin
        if ($urandom_range(99) < 8) ask_cell(IDX_W'($urandom_range(127, DEF_CELL_COUNT)));
        else ask_cell(IDX_W'($urandom_range(DEF_CELL_COUNT - 1)));
      end else begin
        if ($urandom_range(99) < 6) push_digit(VAL_W'($urandom_range(15, DEF_VALUE_COUNT)));
        else push_digit(VAL_W'($urandom_range(DEF_VALUE_COUNT - 1)));
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Nothing counted yet, out-of-range cell, unused type and a clear.
    ask_cell(IDX_W'(0));
    ask_cell(IDX_W'(127));
    send_word(REQ_UNUSED, 4'hF, 7'h7F);
    send_word(REQ_CLEAR, 4'h0, 7'h00);

    // The first frame writes every cell's latest value, so no later query
    // can read a cell that was never written.
    for (int c = 0; c < DEF_CELL_COUNT; c++) push_digit(VAL_W'(c % 10));
    ask_cell(IDX_W'(0));
    ask_cell(IDX_W'(9));
    ask_cell(IDX_W'(DEF_CELL_COUNT - 1));
    ask_cell(IDX_W'(DEF_CELL_COUNT));
    for (int c = 0; c < DEF_CELL_COUNT; c++) push_digit(VAL_W'(9 - c % 10));

    // Two frames with different values give a tie that the lower value wins.
    write_reg(CFG_MIN_VOTE_FRAMES, FRAME_ONE);
    ask_cell(IDX_W'(1));
    ask_cell(IDX_W'(9));
    ask_cell(IDX_W'(DEF_CELL_COUNT - 1));
    for (int c = 0; c < 40; c++) push_digit(4'd15);
    ask_cell(IDX_W'(0));
    send_word(REQ_CLEAR, 4'h0, 7'h00);
    ask_cell(IDX_W'(5));

    random_phase(8'd0, 8'd1, 0, 0, 280, 15);
    random_phase(8'd1, 8'd2, 70, 0, 280, 15);
    random_phase(8'd1, 8'd4, 0, 70, 280, 15);
    random_phase(8'd0, FRAME_MAX, 6, 6, 280, 15);
    random_phase(FRAME_MAX, 8'd1, 0, 0, 100, 20);
    hold_req = 1'b1;
    random_phase(8'd0, 8'd3, 0, 0, 150, 70);
    random_phase(8'd2, 8'd2, 6, 6, 300, 15);

    settle();
    repeat (10) @(negedge clk_i);
    $display("Summary: %0d request words sent, %0d results checked, %0d by majority vote.",
             words_sent, result_count, vote_count);
    $display("Covered ties, skipped frames, out-of-range cells and values, clears, long stall.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
